[hdl/rpcf_pkg.sv]
// Shared widths, constants, reset values and control structs of the roll/pitch filter.
`timescale 1ns / 1ps

package rpcf_pkg;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Fixed-point formats
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int ANGLE_FRAC_BITS = 8;

  // Field and register widths
  localparam int ANG_W  = 24;
  localparam int RATE_W = 16;
  localparam int ACC_W  = 17;
  localparam int TIME_W = 32;
  localparam int BW_W   = 16;
  localparam int IV_W   = 20;
  localparam int SPK_W  = 16;
  localparam int CFG_W  = 20;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE = 2'd3;

  // Register reset values
  localparam logic [BW_W-1:0]  BLEND_RST = 16'd64225;
  localparam logic [IV_W-1:0]  IMIN_RST  = 20'd2000;
  localparam logic [IV_W-1:0]  IMAX_RST  = 20'd50000;
  localparam logic [SPK_W-1:0] SPIKE_RST = 16'd11520;

  // Opcodes
  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Gyro increment: (|rate*dt| << ANGLE_FRAC_BITS + DIV/2) / DIV, DIV = 16 * 10^6.
  // DIV = 2^10 * 15625: drop 10 low bits, then divide by 15625 with a reciprocal
  // multiply that lands at most one low, followed by a remainder check.
  localparam int     DT_W      = IV_W;
  localparam int     MAG_W     = RATE_W - 1 + DT_W;
  localparam int     NUM_W     = MAG_W + ANGLE_FRAC_BITS + 1;
  localparam int     DIV_VAL   = 16 * 1000000;
  localparam int     HALF_DIV  = DIV_VAL / 2;
  localparam int     DIV_SH    = 10;
  localparam int     ODD_DIV   = DIV_VAL >> DIV_SH;
  localparam int     ODD_W     = $clog2(ODD_DIV);
  localparam int     NRM_W     = NUM_W - DIV_SH;
  localparam int     RCP_W     = NRM_W - ODD_W + 1;
  localparam longint RECIP     = (longint'(1) << NRM_W) / ODD_DIV;
  localparam int     Q_W       = RCP_W;
  localparam int     DIV_STEPS = 4;
  localparam int     CNT_W     = $clog2(DIV_STEPS);
  localparam int     INCR_W    = Q_W + 1;
  localparam int     PRED_W    = max2(ANG_W, INCR_W) + 1;

  // Blend arithmetic
  localparam int ONE_A   = 1 << ALPHA_FRAC_BITS;
  localparam int HALF_A  = 1 << (ALPHA_FRAC_BITS - 1);
  localparam int AEFF_W  = ALPHA_FRAC_BITS + 1;
  localparam int AC_W    = max2(BW_W, AEFF_W);
  localparam int MA_W    = max2(RATE_W, AEFF_W + 1);
  localparam int MB_W    = max2(max2(PRED_W, DT_W + 1), ANG_W);
  localparam int P_W     = MA_W + MB_W;
  localparam int SUM_W   = P_W + 2;

  localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic check;
    logic mul_rate;
    logic load_lane;
    logic lane;
    logic div_step;
    logic div_fix;
    logic pred;
    logic mul_alpha;
    logic mul_accel;
    logic write_est;
    logic load_out;
    logic axis;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic restart;
    logic in_window;
  } stat_t;

endpackage

[hdl/rpcf_intf.sv]
// Valid/ready channel interfaces for the input word and the result word.
`timescale 1ns / 1ps

interface rpcf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [rpcf_pkg::TIME_W-1:0]         time_us;
  logic signed [rpcf_pkg::RATE_W-1:0]  roll_rate;
  logic signed [rpcf_pkg::RATE_W-1:0]  pitch_rate;
  logic signed [rpcf_pkg::ACC_W-1:0]   accel_roll;
  logic signed [rpcf_pkg::ACC_W-1:0]   accel_pitch;

  modport source (
    output valid, opcode, time_us, roll_rate, pitch_rate, accel_roll, accel_pitch,
    input  ready
  );
  modport sink (
    input  valid, opcode, time_us, roll_rate, pitch_rate, accel_roll, accel_pitch,
    output ready
  );
endinterface

interface rpcf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rpcf_pkg::ANG_W-1:0]  roll_angle;
  logic signed [rpcf_pkg::ANG_W-1:0]  pitch_angle;
  logic                               accepted;

  modport source (
    output valid, roll_angle, pitch_angle, accepted,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, pitch_angle, accepted,
    output ready
  );
endinterface

[hdl/rpcf_ctrl.sv]
// Sequencing state machine of the roll/pitch filter.
`timescale 1ns / 1ps

module rpcf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rpcf_pkg::stat_t     stat_i,
  output rpcf_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL0  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_LOAD1 = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_PRED  = 4'd6;
  localparam logic [3:0] S_MULA  = 4'd7;
  localparam logic [3:0] S_MULB  = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [rpcf_pkg::CNT_W-1:0] CNT_LAST =
    rpcf_pkg::CNT_W'(rpcf_pkg::DIV_STEPS - 1);

  logic [3:0]                 state_q, state_d;
  logic [rpcf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       axis_q, axis_d;
  logic                       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (stat_i.restart || !stat_i.in_window) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_rate = 1'b1;
        cmd_o.axis     = 1'b0;
        state_d        = S_MUL1;
      end
      S_MUL1: begin
        // roll product goes to its divider lane while pitch is multiplied
        cmd_o.load_lane = 1'b1;
        cmd_o.lane      = 1'b0;
        cmd_o.mul_rate  = 1'b1;
        cmd_o.axis      = 1'b1;
        state_d         = S_LOAD1;
      end
      S_LOAD1: begin
        cmd_o.load_lane = 1'b1;
        cmd_o.lane      = 1'b1;
        cnt_d           = '0;
        state_d         = S_DIV;
      end
      S_DIV: begin
        // estimate roll, estimate pitch, then correct roll and pitch
        cmd_o.div_step = !cnt_q[1];
        cmd_o.div_fix  = cnt_q[1];
        cmd_o.lane     = cnt_q[0];
        cnt_d          = rpcf_pkg::CNT_W'(cnt_q + 1'b1);
        if (cnt_q == CNT_LAST) begin
          axis_d  = 1'b0;
          state_d = S_PRED;
        end
      end
      S_PRED: begin
        cmd_o.pred = 1'b1;
        state_d    = S_MULA;
      end
      S_MULA: begin
        cmd_o.mul_alpha = 1'b1;
        state_d         = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_accel = 1'b1;
        state_d         = S_SUM;
      end
      S_SUM: begin
        cmd_o.write_est = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_PRED;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted word did not enter check");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before taken");

  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_div_cmds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_step || cmd_o.div_fix) |-> (state_q == S_DIV && !(cmd_o.div_step && cmd_o.div_fix)))
    else $error("divider commands out of sequence");

endmodule

[hdl/rpcf_datapath.sv]
// Registers, shared multiplier, two-lane reciprocal divider and blend logic of the filter.
`timescale 1ns / 1ps

module rpcf_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rpcf_pkg::cmd_t                       cmd_i,
  output rpcf_pkg::stat_t                      stat_o,
  input  logic                                 cfg_we_i,
  input  logic [rpcf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rpcf_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 opcode_i,
  input  logic [rpcf_pkg::TIME_W-1:0]          time_us_i,
  input  logic signed [rpcf_pkg::RATE_W-1:0]   roll_rate_i,
  input  logic signed [rpcf_pkg::RATE_W-1:0]   pitch_rate_i,
  input  logic signed [rpcf_pkg::ACC_W-1:0]    accel_roll_i,
  input  logic signed [rpcf_pkg::ACC_W-1:0]    accel_pitch_i,
  output logic signed [rpcf_pkg::ANG_W-1:0]    roll_angle_o,
  output logic signed [rpcf_pkg::ANG_W-1:0]    pitch_angle_o,
  output logic                                 accepted_o
);

  localparam int NRM_W = rpcf_pkg::NRM_W;
  localparam int Q_W   = rpcf_pkg::Q_W;
  localparam int ANG_W = rpcf_pkg::ANG_W;
  localparam int RP_W  = NRM_W + rpcf_pkg::RCP_W;
  localparam int BP_W  = Q_W + rpcf_pkg::ODD_W;
  localparam logic [rpcf_pkg::RCP_W-1:0] RECIP_C = rpcf_pkg::RCP_W'(rpcf_pkg::RECIP);
  localparam logic [rpcf_pkg::ODD_W-1:0] ODD_C   = rpcf_pkg::ODD_W'(rpcf_pkg::ODD_DIV);

  // configuration
  logic [rpcf_pkg::BW_W-1:0]  blend_q;
  logic [rpcf_pkg::IV_W-1:0]  imin_q, imax_q;
  logic [rpcf_pkg::SPK_W-1:0] spike_q;

  // latched input word
  logic                               op_q;
  logic [rpcf_pkg::TIME_W-1:0]        time_q;
  logic signed [rpcf_pkg::RATE_W-1:0] rate_q [2];
  logic signed [rpcf_pkg::ACC_W-1:0]  acc_q  [2];

  // filter state
  logic [rpcf_pkg::TIME_W-1:0] last_q;
  logic signed [ANG_W-1:0]     est_q [2];
  logic [rpcf_pkg::DT_W-1:0]   dt_q;
  logic                        ok_q;

  // arithmetic
  logic signed [rpcf_pkg::P_W-1:0]    prod_q, psum_q;
  logic signed [rpcf_pkg::PRED_W-1:0] pred_q;
  logic signed [ANG_W-1:0]            accsel_q;
  logic                               neg_q [2];
  logic [NRM_W-1:0]                   n_q   [2];
  logic [Q_W-1:0]                     q_q   [2];

  // result register
  logic signed [ANG_W-1:0] out_roll_q, out_pitch_q;
  logic                    out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= rpcf_pkg::BLEND_RST;
      imin_q  <= rpcf_pkg::IMIN_RST;
      imax_q  <= rpcf_pkg::IMAX_RST;
      spike_q <= rpcf_pkg::SPIKE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpcf_pkg::CFG_BLEND: blend_q <= cfg_data_i[rpcf_pkg::BW_W-1:0];
        rpcf_pkg::CFG_IMIN:  imin_q  <= cfg_data_i[rpcf_pkg::IV_W-1:0];
        rpcf_pkg::CFG_IMAX:  imax_q  <= cfg_data_i[rpcf_pkg::IV_W-1:0];
        rpcf_pkg::CFG_SPIKE: spike_q <= cfg_data_i[rpcf_pkg::SPK_W-1:0];
        default: ;
      endcase
    end
  end

  // interval check, modulo 2^32
  logic [rpcf_pkg::TIME_W-1:0] diff;
  logic                        in_window, restart;

  assign diff      = time_q - last_q;
  assign in_window = (diff >= rpcf_pkg::TIME_W'(imin_q)) && (diff <= rpcf_pkg::TIME_W'(imax_q));
  assign restart   = (op_q == rpcf_pkg::OP_RESTART);

  always_comb begin
    stat_o           = '0;
    stat_o.restart   = restart;
    stat_o.in_window = in_window;
  end

  // clamped alpha and its complement
  logic [rpcf_pkg::AC_W-1:0]   blend_ext;
  logic [rpcf_pkg::AEFF_W-1:0] a_eff, one_m_a;

  assign blend_ext = rpcf_pkg::AC_W'(blend_q);
  assign a_eff     = (blend_ext > rpcf_pkg::AC_W'(rpcf_pkg::ONE_A)) ?
                     rpcf_pkg::AEFF_W'(rpcf_pkg::ONE_A) : rpcf_pkg::AEFF_W'(blend_ext);
  assign one_m_a   = rpcf_pkg::AEFF_W'(rpcf_pkg::ONE_A) - a_eff;

  // shared multiplier operand select
  logic signed [rpcf_pkg::MA_W-1:0] mul_a;
  logic signed [rpcf_pkg::MB_W-1:0] mul_b;

  always_comb begin
    mul_a = rpcf_pkg::MA_W'(rate_q[cmd_i.axis]);
    mul_b = $signed(rpcf_pkg::MB_W'(dt_q));
    if (cmd_i.mul_alpha) begin
      mul_a = $signed(rpcf_pkg::MA_W'(a_eff));
      mul_b = rpcf_pkg::MB_W'(pred_q);
    end else if (cmd_i.mul_accel) begin
      mul_a = $signed(rpcf_pkg::MA_W'(one_m_a));
      mul_b = rpcf_pkg::MB_W'(accsel_q);
    end
  end

  // dividend for a lane: |product| scaled to angle units plus half the divisor
  logic                             prod_neg;
  logic signed [rpcf_pkg::P_W-1:0]  prod_abs;
  logic [rpcf_pkg::NUM_W-1:0]       num;

  assign prod_neg = prod_q[rpcf_pkg::P_W-1];
  assign prod_abs = prod_neg ? -prod_q : prod_q;
  assign num = rpcf_pkg::NUM_W'({prod_abs[rpcf_pkg::MAG_W-1:0],
                                 {rpcf_pkg::ANGLE_FRAC_BITS{1'b0}}}) +
               rpcf_pkg::NUM_W'(rpcf_pkg::HALF_DIV);

  // lane quotient by 15625: reciprocal estimate (at most one low), then remainder check
  logic [NRM_W-1:0] n_sel;
  logic [Q_W-1:0]   q_sel;
  logic [RP_W-1:0]  rcp_prod;
  logic [BP_W-1:0]  back_prod;
  logic [NRM_W-1:0] rem;
  logic             rem_hi;

  assign n_sel     = n_q[cmd_i.lane];
  assign q_sel     = q_q[cmd_i.lane];
  assign rcp_prod  = RP_W'(n_sel) * RP_W'(RECIP_C);
  assign back_prod = BP_W'(q_sel) * BP_W'(ODD_C);
  assign rem       = n_sel - back_prod[NRM_W-1:0];
  assign rem_hi    = (rem >= NRM_W'(rpcf_pkg::ODD_DIV));

  // prediction and spike check for the selected axis
  logic signed [ANG_W-1:0]            est_sel;
  logic signed [rpcf_pkg::INCR_W-1:0] q_s, incr;
  logic signed [ANG_W+1:0]            sdiff;
  logic [ANG_W+1:0]                   adiff;
  logic                               spike_hit;

  assign est_sel   = est_q[cmd_i.axis];
  assign q_s       = $signed({1'b0, q_q[cmd_i.axis]});
  assign incr      = neg_q[cmd_i.axis] ? -q_s : q_s;
  assign sdiff     = (ANG_W + 2)'(acc_q[cmd_i.axis]) - (ANG_W + 2)'(est_sel);
  assign adiff     = sdiff[ANG_W+1] ? (ANG_W + 2)'(-sdiff) : sdiff;
  assign spike_hit = adiff > (ANG_W + 2)'(spike_q);

  // blend, round half up, saturate
  logic signed [rpcf_pkg::SUM_W-1:0] sum, sh;
  logic signed [ANG_W-1:0]           blend_new;

  assign sum = rpcf_pkg::SUM_W'(psum_q) + rpcf_pkg::SUM_W'(prod_q) +
               rpcf_pkg::SUM_W'(rpcf_pkg::HALF_A);
  assign sh  = sum >>> rpcf_pkg::ALPHA_FRAC_BITS;

  always_comb begin
    if (sh > rpcf_pkg::SUM_W'(rpcf_pkg::ANG_MAX)) begin
      blend_new = rpcf_pkg::ANG_MAX;
    end else if (sh < rpcf_pkg::SUM_W'(rpcf_pkg::ANG_MIN)) begin
      blend_new = rpcf_pkg::ANG_MIN;
    end else begin
      blend_new = $signed(sh[ANG_W-1:0]);
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      est_q[0] <= '0;
      est_q[1] <= '0;
    end else begin
      if (cmd_i.check) begin
        last_q <= time_q;
        if (restart) begin
          est_q[0] <= '0;
          est_q[1] <= '0;
        end
      end
      if (cmd_i.write_est) begin
        est_q[cmd_i.axis] <= blend_new;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q     <= opcode_i;
      time_q   <= time_us_i;
      rate_q[0] <= roll_rate_i;
      rate_q[1] <= pitch_rate_i;
      acc_q[0]  <= accel_roll_i;
      acc_q[1]  <= accel_pitch_i;
    end
    if (cmd_i.check) begin
      dt_q <= diff[rpcf_pkg::DT_W-1:0];
      ok_q <= !restart && in_window;
    end
    if (cmd_i.mul_rate || cmd_i.mul_alpha || cmd_i.mul_accel) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.mul_accel) begin
      psum_q <= prod_q;
    end
    if (cmd_i.load_lane) begin
      neg_q[cmd_i.lane] <= prod_neg;
      n_q[cmd_i.lane]   <= num[rpcf_pkg::NUM_W-1:rpcf_pkg::DIV_SH];
    end
    if (cmd_i.div_step) begin
      q_q[cmd_i.lane] <= rcp_prod[RP_W-1:NRM_W];
    end
    if (cmd_i.div_fix && rem_hi) begin
      q_q[cmd_i.lane] <= Q_W'(q_sel + 1'b1);
    end
    if (cmd_i.pred) begin
      pred_q   <= rpcf_pkg::PRED_W'(est_sel) + rpcf_pkg::PRED_W'(incr);
      accsel_q <= spike_hit ? est_sel : ANG_W'(acc_q[cmd_i.axis]);
    end
    if (cmd_i.load_out) begin
      out_roll_q  <= est_q[0];
      out_pitch_q <= est_q[1];
      out_ok_q    <= ok_q;
    end
  end

  assign roll_angle_o  = out_roll_q;
  assign pitch_angle_o = out_pitch_q;
  assign accepted_o    = out_ok_q;

endmodule

[hdl/roll_pitch_complementary_filter_core.sv]
// Top level of the roll/pitch complementary filter: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// Roll/pitch complementary filter. Each input word is a restart (zero both
// angles, latch the timestamp) or an update (gyro rates plus accel angles with
// a microsecond timestamp). Every word yields exactly one result word with
// both angles in 1/256 degree, signed 24 bit saturating, and an accepted flag
// that is set only when an update fell inside the configured interval window.
// A restart or a rejected update goes from acceptance through the check
// step to the result load; an applied update runs accept, check, the rate multiplies
// and divider lane loads, the divide steps (estimate roll, estimate pitch, then
// correct roll and pitch), then predict, alpha multiply, accel multiply and sum per
// axis, and a result load. This sequence is set by the division of rate * interval
// by the constant 16e6 (a reciprocal multiply per axis, then a one-step remainder
// correction per axis) and by the single shared multiplier that serves the gyro
// products and the blend. The result sits in an output register, so a new word is
// accepted while the previous result still waits to be taken; the block stalls in its
// final step only when a second result is ready before the first has gone.
// Configuration writes are registered and must only be issued while the block is idle.

module roll_pitch_complementary_filter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpcf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rpcf_pkg::CFG_W-1:0]     cfg_data_i,
  rpcf_in_if.sink                        in_i,
  rpcf_out_if.source                     out_o
);

  rpcf_pkg::cmd_t  cmd;
  rpcf_pkg::stat_t stat;

  // sequencing: owns handshake, step counter and axis select
  rpcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic, filter state, configuration and result register
  rpcf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (in_i.opcode),
    .time_us_i     (in_i.time_us),
    .roll_rate_i   (in_i.roll_rate),
    .pitch_rate_i  (in_i.pitch_rate),
    .accel_roll_i  (in_i.accel_roll),
    .accel_pitch_i (in_i.accel_pitch),
    .roll_angle_o  (out_o.roll_angle),
    .pitch_angle_o (out_o.pitch_angle),
    .accepted_o    (out_o.accepted)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the roll/pitch complementary filter core.
`timescale 1ns / 1ps

module testbench;
  import rpcf_pkg::*;

  // Rate LSB is 1/16 deg/s and time is in us, so a gyro step divides by 16e6
  localparam longint GYRO_DIV        = 64'd16_000_000;
  localparam longint ACC_LIMIT       = 46080;
  localparam longint IVAL_TOP        = 1000000;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     DRAIN_CYCLES    = 60;

  typedef struct packed {
    logic                     opcode;
    logic [TIME_W-1:0]        stamp;
    logic signed [RATE_W-1:0] roll_rate;
    logic signed [RATE_W-1:0] pitch_rate;
    logic signed [ACC_W-1:0]  accel_roll;
    logic signed [ACC_W-1:0]  accel_pitch;
  } imu_word_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic                    accepted;
  } attitude_t;

  // Angle estimates kept wide; they never leave the saturated 24 bit range
  typedef struct packed {
    longint            roll;
    longint            pitch;
    logic [TIME_W-1:0] last_stamp;
  } filter_state_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  rpcf_in_if  imu_if ();
  rpcf_out_if att_if ();

  roll_pitch_complementary_filter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (imu_if),
    .out_o      (att_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the register file, changed only while the core is idle
  longint blend_q16 = longint'(BLEND_RST);
  longint imin_us   = longint'(IMIN_RST);
  longint imax_us   = longint'(IMAX_RST);
  longint spike_lim = longint'(SPIKE_RST);

  // track_st follows accepted words; plan_st runs ahead while words are generated
  filter_state_t track_st = '0;
  filter_state_t plan_st  = '0;

  imu_word_t pending_words[$];
  attitude_t expected_attitudes[$];

  int n_mismatch = 0;
  int n_results  = 0;

  // ---------------------------------------------------------------------------
  // Filter arithmetic
  // ---------------------------------------------------------------------------

  // rate * dt scaled to angle LSBs, rounded to nearest with ties away from zero
  function automatic longint gyro_delta(input longint rate, input longint dt);
    longint prod;
    longint mag;
    longint q;
    prod = rate * dt;
    mag  = (prod < 0) ? -prod : prod;
    mag  = mag << ANGLE_FRAC_BITS;
    q    = (mag + GYRO_DIV / 2) / GYRO_DIV;
    return (prod < 0) ? -q : q;
  endfunction

  function automatic longint fuse_axis(input longint est, input longint rate,
                                       input longint acc, input longint dt);
    longint one;
    longint a;
    longint pred;
    longint diff;
    longint sum;
    longint res;
    one  = longint'(1) << ALPHA_FRAC_BITS;
    a    = (blend_q16 > one) ? one : blend_q16;
    pred = est + gyro_delta(rate, dt);
    diff = acc - est;
    if (diff < 0) diff = -diff;
    // spike check is against the estimate before this update
    if (diff > spike_lim) acc = est;
    // round half up, then saturate
    sum = a * pred + (one - a) * acc + (one >>> 1);
    res = sum >>> ALPHA_FRAC_BITS;
    if (res > longint'(ANG_MAX)) res = longint'(ANG_MAX);
    if (res < longint'(ANG_MIN)) res = longint'(ANG_MIN);
    return res;
  endfunction

  function automatic void filter_step(inout filter_state_t st, input imu_word_t w,
                                      output attitude_t r);
    logic [TIME_W-1:0] dt;
    longint            nr;
    longint            np;
    r.accepted = 1'b0;
    if (w.opcode == OP_RESTART) begin
      st.roll       = 0;
      st.pitch      = 0;
      st.last_stamp = w.stamp;
    end else begin
      // modulo 2^32 interval, timestamp stored even when rejected
      dt            = w.stamp - st.last_stamp;
      st.last_stamp = w.stamp;
      if (dt >= imin_us && dt <= imax_us) begin
        nr = fuse_axis(st.roll, longint'(w.roll_rate), longint'(w.accel_roll), longint'(dt));
        np = fuse_axis(st.pitch, longint'(w.pitch_rate), longint'(w.accel_pitch),
                       longint'(dt));
        st.roll    = nr;
        st.pitch   = np;
        r.accepted = 1'b1;
      end
    end
    r.roll_angle  = st.roll[ANG_W-1:0];
    r.pitch_angle = st.pitch[ANG_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Word generation
  // ---------------------------------------------------------------------------

  function automatic imu_word_t mk_word(input logic op, input logic [TIME_W-1:0] stamp,
                                        input int rr, input int pr,
                                        input longint ar, input longint ap);
    imu_word_t w;
    w.opcode      = op;
    w.stamp       = stamp;
    w.roll_rate   = RATE_W'(rr);
    w.pitch_rate  = RATE_W'(pr);
    w.accel_roll  = ACC_W'(ar);
    w.accel_pitch = ACC_W'(ap);
    return w;
  endfunction

  function automatic void queue_word(input imu_word_t w);
    attitude_t unused;
    filter_step(plan_st, w, unused);
    pending_words.push_back(w);
  endfunction

  // Mostly inside the window, with edges, off-by-one, backwards and wild steps.
  // wide picks the upper half of the window to push the gyro term hard.
  function automatic logic [TIME_W-1:0] pick_interval(input bit wide);
    longint lo;
    longint hi;
    int     k;
    lo = imin_us;
    hi = imax_us;
    k  = $urandom_range(99, 0);
    if (lo > hi) return (k < 50) ? TIME_W'($urandom_range(lo, hi)) : $urandom();
    if (k < 70) begin
      if (wide) return TIME_W'($urandom_range(hi, lo + (hi - lo) / 2));
      return TIME_W'($urandom_range(hi, lo));
    end
    if (k < 76) return TIME_W'(lo);
    if (k < 82) return TIME_W'(hi);
    if (k < 88) return (lo > 0) ? TIME_W'(lo - 1) : TIME_W'(hi + 1);
    if (k < 93) return TIME_W'(hi + 1);
    if (k < 97) return TIME_W'(-longint'($urandom_range(5000, 1)));
    return $urandom();
  endfunction

  function automatic logic [TIME_W-1:0] pick_restart_stamp();
    int k;
    k = $urandom_range(99, 0);
    if (k < 40) return $urandom();
    // close below the wrap so later updates cross zero
    if (k < 70) return 32'hFFFF_FFFF - $urandom_range(3000000, 0);
    return $urandom_range(100000, 0);
  endfunction

  function automatic logic signed [RATE_W-1:0] pick_rate(input int bias);
    int k;
    k = $urandom_range(99, 0);
    if (bias > 0) return (k < 10) ? 16'sh7FFF : RATE_W'($urandom_range(32767, 28000));
    if (bias < 0) return (k < 10) ? 16'sh8000 : RATE_W'(-int'($urandom_range(32767, 28000)));
    if (k < 8)  return 16'sh7FFF;
    if (k < 16) return 16'sh8000;
    if (k < 30) return RATE_W'(int'($urandom_range(200, 0)) - 100);
    return RATE_W'($urandom_range(65535, 0));
  endfunction

  // Accel near the estimate exercises both sides of the spike limit
  function automatic logic signed [ACC_W-1:0] pick_accel(input longint est);
    longint span;
    longint v;
    int     k;
    span = spike_lim + 64;
    k    = $urandom_range(99, 0);
    if (k < 45)      v = est + longint'($urandom_range(2 * span, 0)) - span;
    else if (k < 50) v = est + spike_lim;
    else if (k < 55) v = est - spike_lim - 1;
    else if (k < 58) v = est + spike_lim + 1;
    else if (k < 60) v = est - spike_lim;
    else if (k < 65) v = ACC_LIMIT;
    else if (k < 70) v = -ACC_LIMIT;
    else             v = longint'($urandom_range(2 * ACC_LIMIT, 0)) - ACC_LIMIT;
    if (v > ACC_LIMIT)  v = ACC_LIMIT;
    if (v < -ACC_LIMIT) v = -ACC_LIMIT;
    return v[ACC_W-1:0];
  endfunction

  // Random words; a nonzero bias drives the gyro one way for the first half
  // and the other way for the second, to reach both saturation rails.
  task automatic gen_words(input int count, input int bias);
    int        k;
    int        b;
    imu_word_t w;
    for (int n = 0; n < count; n++) begin
      b        = (bias == 0) ? 0 : ((n < count / 2) ? bias : -bias);
      k        = $urandom_range(99, 0);
      w.opcode = OP_UPDATE;
      if (k < 5) begin
        w.opcode = OP_RESTART;
        w.stamp  = pick_restart_stamp();
      end else begin
        w.stamp = plan_st.last_stamp + pick_interval(b != 0);
      end
      w.roll_rate   = pick_rate(b);
      w.pitch_rate  = pick_rate(b);
      w.accel_roll  = pick_accel(plan_st.roll);
      w.accel_pitch = pick_accel(plan_st.pitch);
      queue_word(w);
    end
  endtask

  // Directed words at the reset register values
  task automatic send_directed();
    queue_word(mk_word(OP_UPDATE, 3000, 100, -100, 1000, -1000));
    queue_word(mk_word(OP_RESTART, 1000, 0, 0, 0, 0));
    // window edges with full-scale rates and accel spikes
    queue_word(mk_word(OP_UPDATE, 3000, 32767, -32768, ACC_LIMIT, -ACC_LIMIT));
    queue_word(mk_word(OP_UPDATE, 53000, -32768, 32767, -ACC_LIMIT, ACC_LIMIT));
    // just short, just long, and backwards
    queue_word(mk_word(OP_UPDATE, 54999, 500, 500, 0, 0));
    queue_word(mk_word(OP_UPDATE, 105000, 500, 500, 0, 0));
    queue_word(mk_word(OP_UPDATE, 104000, 500, 500, 0, 0));
    queue_word(mk_word(OP_UPDATE, 110000, 1200, -1200, 5000, -5000));
    // increments of exactly half an LSB and one and a half: round away from zero
    queue_word(mk_word(OP_UPDATE, 141250, 1, -1, 0, 0));
    queue_word(mk_word(OP_UPDATE, 172500, 3, -3, 0, 0));
    // interval across the 32 bit wrap
    queue_word(mk_word(OP_RESTART, 32'hFFFF_F000, 0, 0, 0, 0));
    queue_word(mk_word(OP_UPDATE, 32'h0000_0400, 16000, -16000, 2000, -2000));
    queue_word(mk_word(OP_UPDATE, 32'h0000_2000, 0, 0, 0, 0));
    // zero interval, huge interval, then minimum interval across the wrap
    queue_word(mk_word(OP_RESTART, 0, 0, 0, 0, 0));
    queue_word(mk_word(OP_UPDATE, 0, 300, 300, 100, 100));
    queue_word(mk_word(OP_UPDATE, 32'hFFFF_FFFF, 300, 300, 100, 100));
    queue_word(mk_word(OP_UPDATE, 32'h0000_07CF, 300, -300, 800, -800));
    // accel exactly at the spike limit is kept, one past is dropped
    queue_word(mk_word(OP_UPDATE, 32'h0000_07CF + 2500, 50, 50,
                       plan_st.roll + spike_lim, plan_st.pitch - spike_lim - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Register writes and phase sequencing
  // ---------------------------------------------------------------------------

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
  endtask

  // Write enable stays high across the four writes and drops once
  task automatic set_registers(input longint blend, input longint imin,
                               input longint imax, input longint spike);
    put_reg(CFG_BLEND, blend);
    put_reg(CFG_IMIN, imin);
    put_reg(CFG_IMAX, imax);
    put_reg(CFG_SPIKE, spike);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    blend_q16 = blend;
    imin_us   = imin;
    imax_us   = imax;
    spike_lim = spike;
  endtask

  // Sender holds off until every expected word is back
  task automatic settle();
    while (pending_words.size() != 0 || imu_if.valid || expected_attitudes.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  bit hold_request = 1'b0;

  task automatic run_phase(input longint blend, input longint imin, input longint imax,
                           input longint spike, input int count, input int bias,
                           input bit hold);
    settle();
    set_registers(blend, imin, imax, spike);
    @(negedge clk_i);
    plan_st = track_st;
    if (hold) hold_request = 1'b1;
    gen_words(count, bias);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------

  int        tx_gap_left   = 0;
  int        tx_burst_left = 1;
  int        tx_roll;
  imu_word_t tx_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_if.valid <= 1'b0;
    end else if (!imu_if.valid || imu_if.ready) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        imu_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        tx_word = pending_words.pop_front();
        imu_if.opcode      <= tx_word.opcode;
        imu_if.time_us     <= tx_word.stamp;
        imu_if.roll_rate   <= tx_word.roll_rate;
        imu_if.pitch_rate  <= tx_word.pitch_rate;
        imu_if.accel_roll  <= tx_word.accel_roll;
        imu_if.accel_pitch <= tx_word.accel_pitch;
        imu_if.valid       <= 1'b1;
        if (tx_burst_left > 1) begin
          tx_burst_left--;
        end else begin
          tx_burst_left = $urandom_range(24, 1);
          tx_roll       = $urandom_range(99, 0);
          // gap 0 merges bursts into long back-to-back stretches
          if (tx_roll < 30)      tx_gap_left = 0;
          else if (tx_roll < 80) tx_gap_left = $urandom_range(4, 1);
          else                   tx_gap_left = $urandom_range(30, 5);
        end
      end else begin
        imu_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches mode every so often; a requested hold-off
  // keeps ready low long enough for the core to back up into its input
  // ---------------------------------------------------------------------------

  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_hold_left = 0;
  int rx_cycle     = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_if.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_request) begin
        rx_hold_left = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(3, 0);
        rx_mode_left = $urandom_range(200, 20);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        att_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       att_if.ready <= 1'b1;
          1:       att_if.ready <= $urandom_range(1, 0);
          2:       att_if.ready <= ($urandom_range(3, 0) == 0);
          default: att_if.ready <= (rx_cycle % 7) < 4;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input word, checks every result word
  // ---------------------------------------------------------------------------

  imu_word_t seen_word;
  attitude_t want;
  attitude_t fresh;

  task automatic flag_error(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("ERROR: %s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // results first; a result never leaves on the edge its input arrives
      if (att_if.valid && att_if.ready) begin
        if (expected_attitudes.size() == 0) begin
          flag_error($sformatf("unexpected result: roll %0d pitch %0d accepted %0b",
                               att_if.roll_angle, att_if.pitch_angle, att_if.accepted));
        end else begin
          want = expected_attitudes.pop_front();
          if (att_if.roll_angle !== want.roll_angle ||
              att_if.pitch_angle !== want.pitch_angle ||
              att_if.accepted !== want.accepted)
            flag_error($sformatf(
              "result %0d: expected roll %0d pitch %0d accepted %0b, got %0d %0d %0b",
              n_results, want.roll_angle, want.pitch_angle, want.accepted,
              att_if.roll_angle, att_if.pitch_angle, att_if.accepted));
        end
        n_results++;
      end
      if (imu_if.valid && imu_if.ready) begin
        seen_word.opcode      = imu_if.opcode;
        seen_word.stamp       = imu_if.time_us;
        seen_word.roll_rate   = imu_if.roll_rate;
        seen_word.pitch_rate  = imu_if.pitch_rate;
        seen_word.accel_roll  = imu_if.accel_roll;
        seen_word.accel_pitch = imu_if.accel_pitch;
        filter_step(track_st, seen_word, fresh);
        expected_attitudes.push_back(fresh);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    imu_if.valid       = 1'b0;
    imu_if.opcode      = OP_UPDATE;
    imu_if.time_us     = '0;
    imu_if.roll_rate   = '0;
    imu_if.pitch_rate  = '0;
    imu_if.accel_roll  = '0;
    imu_if.accel_pitch = '0;
    att_if.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_BLEND;
    cfg_data_i         = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values
    send_directed();
    gen_words(150, 0);

    // accel only, widest window, spike limit at the accel limit
    run_phase(0, 0, IVAL_TOP, ACC_LIMIT, 110, 0, 1'b0);
    // gyro only with every accel dropped: drive both angles into the rails
    run_phase(65535, 0, IVAL_TOP, 0, 120, 1, 1'b0);
    // empty window: every update rejected, timestamps still tracked
    run_phase(20000, IVAL_TOP, 0, 11520, 60, 0, 1'b0);
    // long receiver hold-off while the sender keeps offering
    run_phase(32768, 1000, 20000, 2000, 160, 0, 1'b1);
    // single-point window
    run_phase(1, IVAL_TOP, IVAL_TOP, ACC_LIMIT, 60, 0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      automatic longint lo = $urandom_range(30000, 0);
      run_phase($urandom_range(65535, 0), lo, lo + $urandom_range(60000, 0),
                $urandom_range(ACC_LIMIT, 0), 100, 0, 1'b0);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
hdl/rpcf_pkg.sv
hdl/rpcf_intf.sv
hdl/rpcf_ctrl.sv
hdl/rpcf_datapath.sv
hdl/roll_pitch_complementary_filter_core.sv
sim/testbench.sv
